// File: rtl/gccp_pkg.sv
// Shared types and constants for the GLB container chunk parser.
package gccp_pkg;

  localparam logic [31:0] GLB_MAGIC     = 32'h4654_6C67;
  localparam logic [31:0] TYPE_JSON     = 32'h4E4F_534A;
  localparam logic [31:0] TYPE_BIN      = 32'h004E_4942;
  localparam logic [31:0] GLB_VERSION   = 32'd2;
  localparam logic [31:0] MIN_FILE_LEN  = 32'd20;
  localparam logic [32:0] FILE_HDR_LEN  = 33'd12;
  localparam logic [33:0] CHUNK_HDR_LEN = 34'd8;
  localparam logic [31:0] POS_MAGIC_END = 32'd3;
  localparam logic [31:0] POS_VER_END   = 32'd7;
  localparam logic [31:0] POS_HDR_END   = 32'd11;
  localparam logic [2:0]  HDR_LEN_DONE  = 3'd4;
  localparam logic [2:0]  HDR_TYPE_DONE = 3'd0;
  localparam int unsigned QUEUE_DEPTH   = 4;

  typedef enum logic [1:0] {
    PH_FILE = 2'd0,
    PH_CHDR = 2'd1,
    PH_PAY  = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CLS_HDR  = 3'd0,
    CLS_CHDR = 3'd1,
    CLS_JSON = 3'd2,
    CLS_BIN  = 3'd3,
    CLS_SKIP = 3'd4,
    CLS_TAIL = 3'd5
  } byte_class_e;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_JSON = 2'd1,
    KIND_BIN  = 2'd2
  } chunk_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_HDR  = 2'd1,
    ERR_LEN  = 2'd2,
    ERR_OVF  = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_e cls;
    logic        start;
    logic        last;
    err_e        err;
    logic        short_file;
    logic        len_bad;
  } item_t;

endpackage

// File: rtl/glb_container_chunk_parser_unit.sv
// Top level of the GLB container chunk parser.
// A pushed word passes through the queue and then the back end's result register.
// Throughput: one word per cycle while the queue is not full.
// The queue between front and back ends absorbs stalls on the result side.
// Reset is asynchronous and active low; the parser also returns to its reset state
// after the final byte of each file.
module glb_container_chunk_parser_unit #(
  parameter int unsigned QueueDepth = gccp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] byte_out_o,
  output logic [2:0] byte_class_o,
  output logic       chunk_start_o,
  output logic       done_res_o,
  output logic [1:0] status_o
);
  import gccp_pkg::*;

  logic  accept;
  item_t front_item;
  item_t q_item;
  logic  q_empty;
  logic  q_rd;

  assign accept = push && !full;

  gccp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_o      (front_item)
  );

  gccp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_item_i (front_item),
    .full_o    (full),
    .rd_en_i   (q_rd),
    .rd_item_o (q_item),
    .empty_o   (q_empty)
  );

  gccp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_item_i      (q_item),
    .q_rd_o        (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .byte_out_o    (byte_out_o),
    .byte_class_o  (byte_class_o),
    .chunk_start_o (chunk_start_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o)
  );

endmodule

// File: rtl/gccp_front.sv
// Front end: walks the file header and chunk headers and classifies each byte.
module gccp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output gccp_pkg::item_t item_o
);
  import gccp_pkg::*;

  phase_e      phase_q, phase_d;
  chunk_kind_e kind_q, kind_d;
  err_e        err_q, err_d;
  logic [31:0] byte_count_q, byte_count_d;
  logic [31:0] declared_q, declared_d;
  logic [31:0] word_shift_q, word_shift_d;
  logic [31:0] chunk_rem_q, chunk_rem_d;
  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic        bin_taken_q, bin_taken_d;
  logic        start_pending_q, start_pending_d;

  logic [31:0] ws;
  logic [31:0] decl_new;
  logic [31:0] rem_dec;
  logic [32:0] off;
  logic [32:0] next_off;
  logic [32:0] room;
  logic        fits;
  logic        overflow;
  logic [2:0]  hdr_nx;

  always_comb begin
    ws       = {data_byte_i, word_shift_q[31:8]};
    off      = {1'b0, byte_count_q} + 33'd1;
    next_off = (phase_q == PH_FILE) ? FILE_HDR_LEN : off;
    decl_new = (phase_q == PH_FILE && byte_count_q == POS_HDR_END) ? ws : declared_q;
    fits     = ({1'b0, next_off} + CHUNK_HDR_LEN) <= {2'b00, decl_new};
    room     = {1'b0, declared_q} - off;
    overflow = (off > {1'b0, declared_q}) || ({1'b0, chunk_rem_q} > room);
    hdr_nx   = hdr_pos_q + 3'd1;
    rem_dec  = (chunk_rem_q != 32'd0) ? chunk_rem_q - 32'd1 : chunk_rem_q;

    phase_d         = phase_q;
    kind_d          = kind_q;
    err_d           = err_q;
    byte_count_d    = byte_count_q;
    declared_d      = declared_q;
    word_shift_d    = word_shift_q;
    chunk_rem_d     = chunk_rem_q;
    hdr_pos_d       = hdr_pos_q;
    bin_taken_d     = bin_taken_q;
    start_pending_d = start_pending_q;

    item_o.data  = data_byte_i;
    item_o.cls   = CLS_TAIL;
    item_o.start = 1'b0;
    item_o.last  = last_byte_i;

    if (accept_i) begin
      word_shift_d = ws;
      unique case (phase_q)
        PH_FILE: begin
          item_o.cls = CLS_HDR;
          if (byte_count_q == POS_MAGIC_END && ws != GLB_MAGIC) begin
            err_d = ERR_HDR;
          end
          if (byte_count_q == POS_VER_END && ws != GLB_VERSION && err_q == ERR_NONE) begin
            err_d = ERR_HDR;
          end
          if (byte_count_q == POS_HDR_END) begin
            declared_d = ws;
            if (err_q == ERR_NONE && ws < MIN_FILE_LEN) begin
              err_d = ERR_LEN;
            end
            if (err_d != ERR_NONE || !fits) begin
              phase_d = PH_TAIL;
            end else begin
              phase_d   = PH_CHDR;
              hdr_pos_d = 3'd0;
            end
          end
        end
        PH_CHDR: begin
          item_o.cls = CLS_CHDR;
          hdr_pos_d  = hdr_nx;
          if (hdr_nx == HDR_LEN_DONE) begin
            chunk_rem_d = ws;
          end
          if (hdr_nx == HDR_TYPE_DONE) begin
            if (overflow) begin
              if (err_q == ERR_NONE) begin
                err_d = ERR_OVF;
              end
              phase_d = PH_TAIL;
            end else begin
              if (ws == TYPE_JSON) begin
                kind_d = KIND_JSON;
              end else if (ws == TYPE_BIN && !bin_taken_q && chunk_rem_q != 32'd0) begin
                kind_d      = KIND_BIN;
                bin_taken_d = 1'b1;
              end else begin
                kind_d = KIND_SKIP;
              end
              if (chunk_rem_q == 32'd0) begin
                if (fits) begin
                  phase_d   = PH_CHDR;
                  hdr_pos_d = 3'd0;
                end else begin
                  phase_d = PH_TAIL;
                end
              end else begin
                phase_d         = PH_PAY;
                start_pending_d = 1'b1;
              end
            end
          end
        end
        PH_PAY: begin
          unique case (kind_q)
            KIND_JSON: item_o.cls = CLS_JSON;
            KIND_BIN:  item_o.cls = CLS_BIN;
            default:   item_o.cls = CLS_SKIP;
          endcase
          item_o.start    = start_pending_q && kind_q != KIND_SKIP;
          start_pending_d = 1'b0;
          chunk_rem_d     = rem_dec;
          if (rem_dec == 32'd0) begin
            if (fits) begin
              phase_d   = PH_CHDR;
              hdr_pos_d = 3'd0;
            end else begin
              phase_d = PH_TAIL;
            end
          end
        end
        default: begin
          item_o.cls = CLS_TAIL;
        end
      endcase

      if (byte_count_q != 32'hFFFF_FFFF) begin
        byte_count_d = byte_count_q + 32'd1;
      end
    end

    item_o.err        = err_d;
    item_o.short_file = byte_count_d < MIN_FILE_LEN;
    item_o.len_bad    = (declared_d > byte_count_d) || (declared_d < MIN_FILE_LEN);

    if (accept_i && last_byte_i) begin
      phase_d         = PH_FILE;
      kind_d          = KIND_SKIP;
      err_d           = ERR_NONE;
      byte_count_d    = 32'd0;
      declared_d      = 32'd0;
      word_shift_d    = 32'd0;
      chunk_rem_d     = 32'd0;
      hdr_pos_d       = 3'd0;
      bin_taken_d     = 1'b0;
      start_pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_FILE;
      kind_q          <= KIND_SKIP;
      err_q           <= ERR_NONE;
      byte_count_q    <= 32'd0;
      declared_q      <= 32'd0;
      word_shift_q    <= 32'd0;
      chunk_rem_q     <= 32'd0;
      hdr_pos_q       <= 3'd0;
      bin_taken_q     <= 1'b0;
      start_pending_q <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      kind_q          <= kind_d;
      err_q           <= err_d;
      byte_count_q    <= byte_count_d;
      declared_q      <= declared_d;
      word_shift_q    <= word_shift_d;
      chunk_rem_q     <= chunk_rem_d;
      hdr_pos_q       <= hdr_pos_d;
      bin_taken_q     <= bin_taken_d;
      start_pending_q <= start_pending_d;
    end
  end

`ifndef ASSERT_OFF
  a_file_phase_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FILE |-> byte_count_q <= POS_HDR_END)
    else $error("File header phase lasted past the header.");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> chunk_rem_q != 32'd0)
    else $error("Payload phase with no bytes left.");
`endif

endmodule

// File: rtl/gccp_fifo.sv
// Short queue of classified words between the front and back ends.
module gccp_fifo #(
  parameter int unsigned Depth = gccp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  gccp_pkg::item_t wr_item_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output gccp_pkg::item_t rd_item_o,
  output logic            empty_o
);
  import gccp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  assign rd_item_o = mem_q[rd_ptr_q];
  assign full_o    = cnt_q == CntW'(Depth);
  assign empty_o   = cnt_q == '0;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("Queue count exceeds its depth.");

  a_cnt_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && !rd_en_i |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("Queue count did not follow a write.");
`endif

endmodule

// File: rtl/gccp_back.sv
// Back end: resolves the final status and holds the result word for the consumer.
module gccp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  gccp_pkg::item_t q_item_i,
  output logic            q_rd_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      byte_out_o,
  output logic [2:0]      byte_class_o,
  output logic            chunk_start_o,
  output logic            done_res_o,
  output logic [1:0]      status_o
);
  import gccp_pkg::*;

  logic        valid_q, valid_d;
  logic [7:0]  data_q;
  byte_class_e cls_q;
  logic        start_q;
  logic        last_q;
  err_e        status_q, status_d;
  logic        load;

  always_comb begin
    load    = !q_empty_i && (!valid_q || pop_i);
    valid_d = load || (valid_q && !pop_i);
    if (!q_item_i.last) begin
      status_d = q_item_i.err;
    end else if (q_item_i.short_file || q_item_i.err == ERR_HDR) begin
      status_d = ERR_HDR;
    end else if (q_item_i.len_bad) begin
      status_d = ERR_LEN;
    end else if (q_item_i.err == ERR_OVF) begin
      status_d = ERR_OVF;
    end else begin
      status_d = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q   <= q_item_i.data;
      cls_q    <= q_item_i.cls;
      start_q  <= q_item_i.start;
      last_q   <= q_item_i.last;
      status_q <= status_d;
    end
  end

  assign q_rd_o        = load;
  assign empty_o       = !valid_q;
  assign byte_out_o    = data_q;
  assign byte_class_o  = cls_q;
  assign chunk_start_o = start_q;
  assign done_res_o    = last_q;
  assign status_o      = status_q;

`ifndef ASSERT_OFF
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !pop_i |=> valid_q)
    else $error("Result word dropped while it was not taken.");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench that streams GLB files through the chunk parser and checks every word.
module tb;
  import gccp_pkg::*;

  localparam int ItemTarget = 700;
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 8;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] byte_out_o;
  logic [2:0] byte_class_o;
  logic       chunk_start_o;
  logic       done_res_o;
  logic [1:0] status_o;

  glb_container_chunk_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .empty         (empty),
    .pop           (pop),
    .byte_out_o    (byte_out_o),
    .byte_class_o  (byte_class_o),
    .chunk_start_o (chunk_start_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o)
  );

  class glb_scoreboard;
    typedef struct {
      logic [7:0]  data;
      byte_class_e cls;
      logic        start;
      logic        done;
      err_e        status;
    } glb_result_t;

    glb_result_t results_due[$];
    int          mismatches;
    logic [31:0] seen_bytes;
    logic [31:0] declared_len;
    logic [31:0] word_sr;
    logic [31:0] chunk_left;
    chunk_kind_e kind;
    phase_e      stage;
    bit          bin_taken;
    err_e        err;
    logic [2:0]  hdr_pos;
    bit          first_pending;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      seen_bytes = '0;
      declared_len = '0;
      word_sr = '0;
      chunk_left = '0;
      kind = KIND_SKIP;
      stage = PH_FILE;
      bin_taken = 1'b0;
      err = ERR_NONE;
      hdr_pos = '0;
      first_pending = 1'b0;
    endfunction

    function void next_chunk_or_tail(logic [63:0] off);
      if (off + 64'd8 <= {32'd0, declared_len}) begin
        stage = PH_CHDR;
        hdr_pos = '0;
      end else begin
        stage = PH_TAIL;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [31:0] pos;
      logic [63:0] off;
      glb_result_t r;
      pos = seen_bytes;
      r.data = b;
      r.cls = CLS_TAIL;
      r.start = 1'b0;
      r.done = last;
      word_sr = {b, word_sr[31:8]};
      case (stage)
        PH_FILE: begin
          r.cls = CLS_HDR;
          if (pos == POS_MAGIC_END && word_sr != GLB_MAGIC) err = ERR_HDR;
          if (pos == POS_VER_END && word_sr != GLB_VERSION && err == ERR_NONE) err = ERR_HDR;
          if (pos == POS_HDR_END) begin
            declared_len = word_sr;
            if (err == ERR_NONE && declared_len < MIN_FILE_LEN) err = ERR_LEN;
            if (err != ERR_NONE) stage = PH_TAIL;
            else next_chunk_or_tail(64'd12);
          end
        end
        PH_CHDR: begin
          r.cls = CLS_CHDR;
          hdr_pos = hdr_pos + 3'd1;
          if (hdr_pos == HDR_LEN_DONE) chunk_left = word_sr;
          if (hdr_pos == HDR_TYPE_DONE) begin
            off = {32'd0, pos} + 64'd1;
            if (off > {32'd0, declared_len} ||
                {32'd0, chunk_left} > {32'd0, declared_len} - off) begin
              if (err == ERR_NONE) err = ERR_OVF;
              stage = PH_TAIL;
            end else begin
              if (word_sr == TYPE_JSON) begin
                kind = KIND_JSON;
              end else if (word_sr == TYPE_BIN && !bin_taken && chunk_left != 0) begin
                kind = KIND_BIN;
                bin_taken = 1'b1;
              end else begin
                kind = KIND_SKIP;
              end
              if (chunk_left == 0) begin
                next_chunk_or_tail(off);
              end else begin
                stage = PH_PAY;
                first_pending = 1'b1;
              end
            end
          end
        end
        PH_PAY: begin
          case (kind)
            KIND_JSON: r.cls = CLS_JSON;
            KIND_BIN:  r.cls = CLS_BIN;
            default:   r.cls = CLS_SKIP;
          endcase
          r.start = first_pending && kind != KIND_SKIP;
          first_pending = 1'b0;
          if (chunk_left != 0) chunk_left = chunk_left - 32'd1;
          if (chunk_left == 0) next_chunk_or_tail({32'd0, pos} + 64'd1);
        end
        default: r.cls = CLS_TAIL;
      endcase
      if (seen_bytes != 32'hFFFF_FFFF) seen_bytes = seen_bytes + 32'd1;
      r.status = err;
      if (last) begin
        if (seen_bytes < MIN_FILE_LEN || err == ERR_HDR) r.status = ERR_HDR;
        else if (declared_len > seen_bytes || declared_len < MIN_FILE_LEN) r.status = ERR_LEN;
        else if (err == ERR_OVF) r.status = ERR_OVF;
        else r.status = ERR_NONE;
      end
      results_due = {results_due, r};
      if (last) clear();
    endfunction

    function void check_result(logic [7:0] d, logic [2:0] cls, logic st, logic dn,
                               logic [1:0] stat);
      glb_result_t r;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Word with nothing expected: byte %02h class %0d start %0d done %0d status %0d",
                   d, cls, st, dn, stat);
        return;
      end
      r = results_due.pop_front();
      if (d !== r.data || cls !== r.cls || st !== r.start || dn !== r.done ||
          stat !== r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected byte %02h class %0d start %0d done %0d status %0d, %s",
                   r.data, r.cls, r.start, r.done, r.status,
                   $sformatf("got byte %02h class %0d start %0d done %0d status %0d",
                             d, cls, st, dn, stat));
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  glb_scoreboard sb = new();
  logic [7:0]    file_q[$];
  int            sent = 0;
  int            cycles = 0;
  bit            calm_in = 1'b0;
  bit            calm_out = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void put_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) file_q = {file_q, w[8*k +: 8]};
  endfunction

  function automatic void set_word(int idx, logic [31:0] w);
    for (int k = 0; k < 4; k++) file_q[idx + k] = w[8*k +: 8];
  endfunction

  function automatic void put_noise(int n);
    repeat (n) file_q = {file_q, 8'($urandom_range(0, 255))};
  endfunction

  // Builds a well-formed file and then often damages it in one way.
  function automatic void build_file();
    int          shape;
    int          nchunks;
    int          len;
    int          pick;
    logic [31:0] total;
    logic [31:0] ctype;
    file_q.delete();
    put_word(GLB_MAGIC);
    put_word(GLB_VERSION);
    put_word(32'd0);
    nchunks = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < nchunks; i++) begin
      pick = $urandom_range(0, 9);
      ctype = (pick < 4) ? TYPE_JSON : (pick < 8) ? TYPE_BIN : $urandom();
      if ($urandom_range(0, 4) == 0) len = 0;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
      else len = $urandom_range(1, 12);
      put_word(32'(len));
      put_word(ctype);
      put_noise(len);
    end
    if ($urandom_range(0, 4) == 0) put_noise($urandom_range(1, 7));
    total = 32'(file_q.size());
    set_word(8, total);
    shape = $urandom_range(0, 99);
    if (shape < 15) begin
      put_noise($urandom_range(1, 6));
    end else if (shape < 25) begin
      file_q[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    end else if (shape < 33) begin
      file_q[$urandom_range(4, 7)] ^= 8'(1 << $urandom_range(0, 7));
    end else if (shape < 40) begin
      set_word(8, 32'($urandom_range(0, 19)));
    end else if (shape < 46) begin
      set_word(8, $urandom());
    end else if (shape < 56) begin
      repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
    end else if (shape < 66) begin
      if (total > MIN_FILE_LEN) set_word(8, 32'($urandom_range(20, total - 1)));
    end else if (shape < 74) begin
      if (nchunks > 0) set_word(12, $urandom());
    end else if (shape < 78) begin
      file_q.delete();
      put_noise($urandom_range(1, 30));
    end
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    gap = draw_gap(calm_in);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_byte(d, l);
    sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(calm_out);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check_result(byte_out_o, byte_class_o, chunk_start_o, done_res_o, status_o);
    end
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    // A minimal valid file with a one-byte JSON chunk, then a short file with a bad magic.
    file_q.delete();
    put_word(GLB_MAGIC);
    put_word(GLB_VERSION);
    put_word(32'd21);
    put_word(32'd1);
    put_word(TYPE_JSON);
    file_q = {file_q, 8'hFF};
    send_file();
    file_q = {8'h00, 8'hFF, 8'h00, 8'hFF};
    send_file();
    while (sent < ItemTarget) begin
      build_file();
      send_file();
    end
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
